@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("square root checker: assertion failed");

// condition in one cycle implies a consequence in the next
`define CHK_NEXT(lbl, clk, rst_n, cond, nxt) \
	`CHK_ASSERT(lbl, clk, rst_n, (cond) |=> (nxt))

`endif

@@ rtl/sqr2m_pkg.sv @@
// shared constants and types of the two-method square root block
`default_nettype none
package sqr2m_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int RADICAND_BITS = 16;

	// estimate / bound width, radicand square width, product width
	localparam int X_W    = RADICAND_BITS + FRACTION_BITS;
	localparam int SQ_W   = RADICAND_BITS + 2 * FRACTION_BITS;
	localparam int PROD_W = 2 * X_W;
	localparam int CNT_W  = $clog2(SQ_W + 1);

	localparam int ROOT_W  = 24;
	localparam int RAD_W   = 16;
	localparam int CFG_W   = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CFG_W-1:0] TOL_RESET   = 16'd66;
	localparam logic [CFG_W-1:0] LIMIT_RESET = 16'd32767;

	// register index taken from paddr[2]
	localparam logic REG_TOLERANCE   = 1'b0;
	localparam logic REG_INPUT_LIMIT = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] tolerance;
		logic [CFG_W-1:0] input_limit;
	} cfg_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic            start;
		alu_op_t         op;
		logic [SQ_W-1:0] lo;
		logic [X_W-1:0]  opnd;
	} alu_req_t;

	typedef struct packed {
		logic            done;
		logic [X_W-1:0]  hi;
		logic [SQ_W-1:0] lo;
	} alu_rsp_t;

endpackage
`default_nettype wire

@@ rtl/sqr2m_cfg.sv @@
// apb register file: tolerance and input limit
`default_nettype none
module sqr2m_cfg import sqr2m_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [CFG_W-1:0] tol_q;
	logic [CFG_W-1:0] limit_q;
	logic             wr_en;
	logic             reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RESET;
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TOLERANCE:   tol_q   <= pwdata[CFG_W-1:0];
				REG_INPUT_LIMIT: limit_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TOLERANCE:   prdata = PDATA_W'(tol_q);
			REG_INPUT_LIMIT: prdata = PDATA_W'(limit_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.tolerance   = tol_q;
	assign cfg.input_limit = limit_q;

endmodule
`default_nettype wire

@@ rtl/sqr2m_alu.sv @@
// shared shift-add unit: restoring divide or shift-add multiply, one bit per cycle
`default_nettype none
module sqr2m_alu import sqr2m_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [X_W:0]     acc_q;
	logic [SQ_W-1:0]  lo_q;
	logic [X_W-1:0]   opnd_q;
	alu_op_t          op_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic             is_div;
	logic [X_W:0]     r_div;
	logic [X_W:0]     a_in;
	logic [X_W:0]     b_in;
	logic [X_W+1:0]   sum;
	logic             ge;
	logic [X_W:0]     acc_n;
	logic [SQ_W-1:0]  lo_n;

	assign is_div = (op_q == OP_DIV);
	// divide: partial remainder shifted left with the next dividend bit
	assign r_div  = {acc_q[X_W-1:0], lo_q[SQ_W-1]};
	assign a_in   = is_div ? r_div : acc_q;
	assign b_in   = is_div ? ~{1'b0, opnd_q} : (lo_q[0] ? {1'b0, opnd_q} : '0);
	// one adder for both: subtract with carry in on divide
	assign sum    = {1'b0, a_in} + {1'b0, b_in} + {{(X_W + 1){1'b0}}, is_div};
	assign ge     = sum[X_W+1];

	always_comb begin
		if (is_div) begin
			acc_n = ge ? sum[X_W:0] : r_div;
			lo_n  = {lo_q[SQ_W-2:0], ge};
		end else begin
			acc_n = {1'b0, sum[X_W:1]};
			lo_n  = {lo_q[SQ_W-1:X_W], sum[0], lo_q[X_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			lo_q   <= '0;
			opnd_q <= '0;
			op_q   <= OP_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			acc_q  <= '0;
			lo_q   <= req.lo;
			opnd_q <= req.opnd;
			op_q   <= req.op;
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= (req.op == OP_DIV) ? CNT_W'(SQ_W) : CNT_W'(X_W);
		end else if (busy_q) begin
			acc_q  <= acc_n;
			lo_q   <= lo_n;
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.hi   = acc_q[X_W-1:0];
	assign rsp.lo   = lo_q;

endmodule
`default_nettype wire

@@ rtl/sqr2m_seq.sv @@
// sequencer: newton and bisection loops around the shared unit, output register
`default_nettype none
module sqr2m_seq import sqr2m_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [RAD_W-1:0]  radicand,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] root,
	output logic              range_error,
	output alu_req_t          alu_req,
	input  alu_rsp_t          alu_rsp
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NEWT_WAIT,
		ST_NEWT_CHK,
		ST_BIS_TEST,
		ST_BIS_MID,
		ST_BIS_WAIT,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [SQ_W-1:0]     sq_q;
	logic [X_W-1:0]      a_q;      // newton: previous estimate, bisection: upper bound
	logic [X_W-1:0]      b_q;      // newton: new estimate, bisection: lower bound
	logic [X_W-1:0]      guess_q;
	logic [X_W-1:0]      w_q;
	logic [X_W-1:0]      res_q;
	logic                err_q;
	alu_req_t            req_q;
	logic                out_valid_q;
	logic [ROOT_W-1:0]   root_q;
	logic                range_error_q;

	logic [RADICAND_BITS-1:0] n;
	logic                     over_limit;
	logic [X_W-1:0]           x0;
	logic [SQ_W-1:0]          sq0;
	logic [CFG_W-1:0]         tol_eff;
	logic [CFG_W-1:0]         stop_min;
	logic [SQ_W:0]            avg_sum;
	logic [X_W-1:0]           x_new;
	logic [X_W:0]             step_d;
	logic                     newt_go;
	logic [X_W:0]             width_d;
	logic                     bis_go;
	logic [X_W-1:0]           mid;
	logic [PROD_W-1:0]        prod;
	logic                     prod_gt;
	logic                     alu_start;
	logic                     out_load;

	assign n          = RADICAND_BITS'(radicand);
	assign over_limit = X_W'(n) > X_W'(cfg.input_limit);
	assign x0         = X_W'(n) << FRACTION_BITS;
	assign sq0        = SQ_W'(n) << (2 * FRACTION_BITS);

	// zero tolerance behaves as one for Newton; bisection also stops below a width of two
	assign tol_eff  = (cfg.tolerance == '0) ? CFG_W'(1) : cfg.tolerance;
	assign stop_min = (cfg.tolerance < CFG_W'(2)) ? CFG_W'(2) : cfg.tolerance;

	assign avg_sum = {1'b0, alu_rsp.lo} + (SQ_W + 1)'(a_q);
	assign x_new   = X_W'(avg_sum[SQ_W:1]);

	// keep going only while the estimate drops by at least the tolerance
	assign step_d  = {1'b0, a_q} - {1'b0, b_q};
	assign newt_go = !step_d[X_W] && (step_d[X_W-1:0] >= X_W'(tol_eff));

	assign width_d = {1'b0, a_q} - {1'b0, b_q};
	assign bis_go  = !width_d[X_W] && (width_d[X_W-1:0] >= X_W'(stop_min));
	assign mid     = b_q + (w_q >> 1);

	assign prod    = {alu_rsp.hi, alu_rsp.lo[X_W-1:0]};
	assign prod_gt = prod > PROD_W'(sq_q);

	// start pulse for the shared unit
	always_comb begin
		unique case (state_q)
			ST_IDLE:     alu_start = in_valid && !over_limit && !req_type && (n != '0);
			ST_NEWT_CHK: alu_start = (b_q != '0) && newt_go;
			ST_BIS_MID:  alu_start = 1'b1;
			default:     alu_start = 1'b0;
		endcase
	end

	// output register takes a result when empty or being drained
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sq_q          <= '0;
			a_q           <= '0;
			b_q           <= '0;
			guess_q       <= '0;
			w_q           <= '0;
			res_q         <= '0;
			err_q         <= 1'b0;
			req_q         <= '0;
			out_valid_q   <= 1'b0;
			root_q        <= '0;
			range_error_q <= 1'b0;
		end else begin
			req_q.start <= alu_start;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sq_q    <= sq0;
						a_q     <= x0;
						b_q     <= '0;
						guess_q <= '0;
						err_q   <= 1'b0;
						if (over_limit) begin
							res_q   <= '0;
							err_q   <= 1'b1;
							state_q <= ST_DONE;
						end else if (req_type) begin
							state_q <= ST_BIS_TEST;
						end else if (n == '0) begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							req_q.op    <= OP_DIV;
							req_q.lo    <= sq0;
							req_q.opnd  <= x0;
							state_q     <= ST_NEWT_WAIT;
						end
					end
				end
				ST_NEWT_WAIT: begin
					if (alu_rsp.done) begin
						b_q     <= x_new;
						state_q <= ST_NEWT_CHK;
					end
				end
				ST_NEWT_CHK: begin
					if (b_q == '0) begin
						res_q   <= '0;
						state_q <= ST_DONE;
					end else if (newt_go) begin
						a_q         <= b_q;
						req_q.op    <= OP_DIV;
						req_q.lo    <= sq_q;
						req_q.opnd  <= b_q;
						state_q     <= ST_NEWT_WAIT;
					end else begin
						res_q   <= b_q;
						state_q <= ST_DONE;
					end
				end
				ST_BIS_TEST: begin
					if (bis_go) begin
						w_q     <= width_d[X_W-1:0];
						state_q <= ST_BIS_MID;
					end else begin
						res_q   <= guess_q;
						state_q <= ST_DONE;
					end
				end
				ST_BIS_MID: begin
					guess_q     <= mid;
					req_q.op    <= OP_MUL;
					req_q.lo    <= SQ_W'(mid);
					req_q.opnd  <= mid;
					state_q     <= ST_BIS_WAIT;
				end
				ST_BIS_WAIT: begin
					if (alu_rsp.done) begin
						if (prod_gt) begin
							a_q <= guess_q;
						end else begin
							b_q <= guess_q;
						end
						state_q <= ST_BIS_TEST;
					end
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (out_load) begin
						root_q        <= ROOT_W'(res_q);
						range_error_q <= err_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign alu_req     = req_q;
	assign out_valid   = out_valid_q;
	assign root        = root_q;
	assign range_error = range_error_q;

endmodule
`default_nettype wire

@@ rtl/square_root_two_method.sv @@
// top level of the two-method square root block
`default_nettype none
// Square root of a 16-bit unsigned radicand, returned as unsigned Q8.16 in root.
// req_type 0 selects the Newton iteration, 1 selects interval bisection; both run
// on one shared shift-add unit that retires one bit per clock, so one item is in
// flight at a time and in_ready is high only while the block is idle. Each Newton
// step runs a 48-bit restoring divide and each bisection step a 32-bit shift-add
// square; a range error, or a zero radicand with Newton, skips the shared unit.
// The finished result sits in an output register, and the next beat can be
// accepted while it waits. Registers over the APB port: tolerance at 0x0 (reset
// 66) and input_limit at 0x4 (reset 32767).
module square_root_two_method import sqr2m_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [RAD_W-1:0]   radicand,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROOT_W-1:0]  root,
	output logic               range_error
);

	cfg_t     cfg;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	sqr2m_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sqr2m_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	sqr2m_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.radicand    (radicand),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.root        (root),
		.range_error (range_error),
		.alu_req     (alu_req),
		.alu_rsp     (alu_rsp)
	);

endmodule
`default_nettype wire

@@ rtl/sqr2m_checker.sv @@
// port-level checker for the square root block, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module sqr2m_checker import sqr2m_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ROOT_W-1:0] root,
	input logic              range_error
);

	// a stalled result beat holds
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(root) && $stable(range_error))

	// out of range gives a zero root
	`CHK_ASSERT(a_err_zero, clk, arst_n, (out_valid && range_error) |-> (root == '0))

	// busy right after an accepted beat
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a new result only appears while the block was busy
	`CHK_ASSERT(a_result_from_work, clk, arst_n, $rose(out_valid) |-> !$past(in_ready))

endmodule

bind square_root_two_method sqr2m_checker u_sqr2m_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.root        (root),
	.range_error (range_error)
);
`default_nettype wire
